>>> src/bftr_pkg.sv
// Shared constants, register indexes and types of the bitmap font text renderer.
package bftr_pkg;

    localparam int GLYPH_ENTRIES    = 256;
    localparam int BITMAP_BYTES     = 4096;
    localparam int MAX_GLYPH_WIDTH  = 32;
    localparam int MAX_GLYPH_HEIGHT = 16;

    localparam int GLYPH_AW  = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int BITMAP_AW = $clog2(BITMAP_BYTES);
    localparam int HEIGHT_W  = $clog2(MAX_GLYPH_HEIGHT + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] SPACE_CODE = 8'h20;

    // Item kinds
    localparam logic [1:0] KIND_GLYPH  = 2'd0;
    localparam logic [1:0] KIND_BITMAP = 2'd1;
    localparam logic [1:0] KIND_DRAW   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_FIRST_CHAR   = 3'd0;
    localparam logic [2:0] REG_LAST_CHAR    = 3'd1;
    localparam logic [2:0] REG_SPACE_WIDTH  = 3'd2;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FILL_BG      = 3'd4;
    localparam logic [2:0] REG_FORE_COLOR   = 3'd5;
    localparam logic [2:0] REG_BACK_COLOR   = 3'd6;

    typedef struct packed {
        logic [5:0]  width;
        logic [11:0] offset;
    } t_glyph;

    // One command from the front end to the drawing engine.
    typedef struct packed {
        logic                is_load;
        logic                empty;
        logic [15:0]         x0;
        logic [15:0]         y0;
        logic [7:0]          adv;
        logic [15:0]         str_w;
        logic [5:0]          w;
        logic [HEIGHT_W-1:0] h;
        logic [11:0]         off;
        logic                fill;
        logic [7:0]          data;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_fifo_status;

endpackage

>>> src/bftr_if.sv
// Channel interfaces of the bitmap font text renderer.
interface bftr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        string_start;
    logic [7:0]  glyph_index;
    logic [5:0]  glyph_width;
    logic [11:0] glyph_offset;
    logic [11:0] bitmap_address;
    logic [7:0]  bitmap_byte;

    modport source (
        output valid, kind, char_code, pos_x, pos_y, string_start, glyph_index,
               glyph_width, glyph_offset, bitmap_address, bitmap_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, char_code, pos_x, pos_y, string_start, glyph_index,
               glyph_width, glyph_offset, bitmap_address, bitmap_byte,
        output ready
    );
endinterface

interface bftr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] seg_x;
    logic [15:0] seg_y;
    logic [3:0]  pixel_count;
    logic [7:0]  fore_mask;
    logic [7:0]  draw_mask;
    logic [7:0]  char_advance;
    logic [15:0] string_width;
    logic        last;

    modport source (
        output valid, seg_x, seg_y, pixel_count, fore_mask, draw_mask, char_advance,
               string_width, last,
        input  ready
    );
    modport sink (
        input  valid, seg_x, seg_y, pixel_count, fore_mask, draw_mask, char_advance,
               string_width, last,
        output ready
    );
endinterface

>>> src/bftr_front.sv
// Front end: configuration, glyph table, cursor tracking and command building.
module bftr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bftr_in_if.sink              i_in,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  bftr_pkg::t_fifo_status i_fifo_st,
    output logic                 o_push,
    output bftr_pkg::t_cmd       o_cmd
);

    localparam int HEIGHT_W_L = bftr_pkg::HEIGHT_W;

    logic [7:0]  r_first_char;
    logic [7:0]  r_last_char;
    logic [4:0]  r_space_width;
    logic [4:0]  r_glyph_height;
    logic        r_fill_bg;
    logic [15:0] r_fore_color;
    logic [15:0] r_back_color;

    logic [15:0] r_origin_x;
    logic [15:0] r_origin_y;
    logic [15:0] r_cursor;

    bftr_pkg::t_glyph r_glyph_mem [bftr_pkg::GLYPH_ENTRIES];
    bftr_pkg::t_glyph r_glyph_q;

    logic        r_s1_valid;
    logic        r_s1_draw;
    logic [7:0]  r_s1_char;
    logic [15:0] r_s1_pos_x;
    logic [15:0] r_s1_pos_y;
    logic        r_s1_start;
    logic [11:0] r_s1_addr;
    logic [7:0]  r_s1_byte;

    logic        accept;
    logic        glyph_wr_ok;
    logic        bitmap_wr_ok;
    logic        enter_s1;
    logic [7:0]  rd_diff;
    logic [8:0]  font_idx;
    logic        in_font;
    logic [6:0]  w_raw;
    logic [5:0]  w_sat;
    logic [7:0]  space_adv;
    logic [7:0]  adv;
    logic [5:0]  w_use;
    logic        empty;
    logic [HEIGHT_W_L-1:0] h_sat;
    logic [15:0] cur_base;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] n_cursor;

    assign accept       = i_in.valid && i_in.ready;
    assign glyph_wr_ok  = {1'b0, i_in.glyph_index} < 9'(bftr_pkg::GLYPH_ENTRIES);
    assign bitmap_wr_ok = {5'b0, i_in.bitmap_address} < 17'(bftr_pkg::BITMAP_BYTES);
    assign enter_s1     = (i_in.kind == bftr_pkg::KIND_DRAW) ||
                          ((i_in.kind == bftr_pkg::KIND_BITMAP) && bitmap_wr_ok);

    assign o_push     = r_s1_valid && i_fifo_st.not_full;
    assign i_in.ready = !r_s1_valid || i_fifo_st.not_full;

    assign rd_diff = i_in.char_code - r_first_char;

    // Glyph table: written by glyph loads, read when a draw beat is taken.
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.kind == bftr_pkg::KIND_GLYPH) && glyph_wr_ok) begin
            r_glyph_mem[i_in.glyph_index[bftr_pkg::GLYPH_AW-1:0]] <=
                '{width: i_in.glyph_width, offset: i_in.glyph_offset};
        end
        if (accept && (i_in.kind == bftr_pkg::KIND_DRAW)) begin
            r_glyph_q <= r_glyph_mem[rd_diff[bftr_pkg::GLYPH_AW-1:0]];
        end
    end

    always_comb begin
        font_idx  = {1'b0, r_s1_char} - {1'b0, r_first_char};
        in_font   = (r_s1_char >= r_first_char) && (r_s1_char <= r_last_char) &&
                    (font_idx < 9'(bftr_pkg::GLYPH_ENTRIES));
        w_raw     = {1'b0, r_glyph_q.width};
        w_sat     = (w_raw > 7'(bftr_pkg::MAX_GLYPH_WIDTH)) ?
                    6'(bftr_pkg::MAX_GLYPH_WIDTH) : r_glyph_q.width;
        space_adv = {1'b0, r_space_width, 2'b00} + {3'b000, r_space_width};
        h_sat     = ({1'b0, r_glyph_height} > 6'(bftr_pkg::MAX_GLYPH_HEIGHT)) ?
                    HEIGHT_W_L'(bftr_pkg::MAX_GLYPH_HEIGHT) : HEIGHT_W_L'(r_glyph_height);

        if (r_s1_char == bftr_pkg::SPACE_CODE) begin
            adv   = space_adv;
            w_use = 6'd0;
        end else if (in_font) begin
            adv   = {2'b00, w_sat};
            w_use = w_sat;
        end else begin
            adv   = 8'd0;
            w_use = 6'd0;
        end
        empty = (w_use == 6'd0) || (h_sat == '0);

        cur_base = r_s1_start ? 16'd0 : r_cursor;
        ox       = r_s1_start ? r_s1_pos_x : r_origin_x;
        oy       = r_s1_start ? r_s1_pos_y : r_origin_y;
        n_cursor = cur_base + {8'd0, adv} + {11'd0, r_space_width};

        o_cmd.is_load = !r_s1_draw;
        o_cmd.empty   = empty;
        o_cmd.x0      = ox + cur_base;
        o_cmd.y0      = oy;
        o_cmd.adv     = adv;
        o_cmd.str_w   = n_cursor - {11'd0, r_space_width};
        o_cmd.w       = w_use;
        o_cmd.h       = h_sat;
        o_cmd.off     = r_s1_draw ? r_glyph_q.offset : r_s1_addr;
        o_cmd.fill    = r_fill_bg;
        o_cmd.data    = r_s1_byte;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_draw  <= (i_in.kind == bftr_pkg::KIND_DRAW);
            r_s1_char  <= i_in.char_code;
            r_s1_pos_x <= i_in.pos_x;
            r_s1_pos_y <= i_in.pos_y;
            r_s1_start <= i_in.string_start;
            r_s1_addr  <= i_in.bitmap_address;
            r_s1_byte  <= i_in.bitmap_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_char   <= 8'd32;
            r_last_char    <= 8'd126;
            r_space_width  <= 5'd2;
            r_glyph_height <= 5'd16;
            r_fill_bg      <= 1'b0;
            r_fore_color   <= 16'hFFFF;
            r_back_color   <= 16'h0000;
            r_origin_x     <= 16'd0;
            r_origin_y     <= 16'd0;
            r_cursor       <= 16'd0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bftr_pkg::REG_FIRST_CHAR:   r_first_char   <= i_cfg_data[7:0];
                    bftr_pkg::REG_LAST_CHAR:    r_last_char    <= i_cfg_data[7:0];
                    bftr_pkg::REG_SPACE_WIDTH:  r_space_width  <= i_cfg_data[4:0];
                    bftr_pkg::REG_GLYPH_HEIGHT: r_glyph_height <= i_cfg_data[4:0];
                    bftr_pkg::REG_FILL_BG:      r_fill_bg      <= i_cfg_data[0];
                    bftr_pkg::REG_FORE_COLOR:   r_fore_color   <= i_cfg_data;
                    bftr_pkg::REG_BACK_COLOR:   r_back_color   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (o_push && r_s1_draw) begin
                if (r_s1_start) begin
                    r_origin_x <= r_s1_pos_x;
                    r_origin_y <= r_s1_pos_y;
                end
                r_cursor <= n_cursor;
            end

            if (accept) begin
                r_s1_valid <= enter_s1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // The colour registers are stored but drive no output here; they only feed unused_colors.
    logic unused_colors;
    assign unused_colors = ^{r_fore_color, r_back_color};

endmodule

>>> src/bftr_fifo.sv
// Short command queue between the front end and the drawing engine.
module bftr_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bftr_pkg::t_cmd          i_cmd,
    input  logic                    i_pop,
    output bftr_pkg::t_cmd          o_cmd,
    output bftr_pkg::t_fifo_status  o_st
);

    bftr_pkg::t_cmd r_mem [bftr_pkg::FIFO_DEPTH];
    logic [bftr_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [bftr_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [bftr_pkg::FIFO_AW:0]   r_count;

    assign o_st.not_empty = (r_count != '0);
    assign o_st.not_full  = (r_count != (bftr_pkg::FIFO_AW + 1)'(bftr_pkg::FIFO_DEPTH));
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> src/bftr_back.sv
// Drawing engine: bitmap store, row and byte sequencing, result register.
module bftr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bftr_pkg::t_cmd         i_cmd,
    input  bftr_pkg::t_fifo_status i_fifo_st,
    output logic                   o_pop,
    bftr_out_if.source             o_out
);

    localparam int HW = bftr_pkg::HEIGHT_W;
    localparam int AW = bftr_pkg::BITMAP_AW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    bftr_pkg::t_cmd r_cmd;

    logic [5:0]    r_left;
    logic [HW-1:0] r_rows;
    logic [AW-1:0] r_addr;
    logic [15:0]   r_seg_x;
    logic [15:0]   r_seg_y;

    logic [7:0]    r_bitmap [bftr_pkg::BITMAP_BYTES];
    logic [7:0]    r_rd;

    logic          r_o_valid;
    logic [15:0]   r_o_x;
    logic [15:0]   r_o_y;
    logic [3:0]    r_o_cnt;
    logic [7:0]    r_o_adv;
    logic [15:0]   r_o_sw;
    logic          r_o_last;
    logic          r_o_fill;

    logic          slot_free;
    logic          run_issue;
    logic          empty_issue;
    logic          row_end;
    logic          glyph_end;
    logic [3:0]    step_cnt;
    logic [16:0]   wide_addr;
    logic [8:0]    low_mask9;
    logic [7:0]    low_mask;
    logic [7:0]    rev_line;

    assign slot_free   = !r_o_valid || o_out.ready;
    assign o_pop       = (r_state == ST_IDLE) && i_fifo_st.not_empty;
    assign run_issue   = (r_state == ST_RUN) && slot_free;
    assign empty_issue = (r_state == ST_EMPTY) && slot_free;
    assign row_end     = (r_left <= 6'd8);
    assign glyph_end   = row_end && (r_rows == HW'(1));
    assign step_cnt    = row_end ? r_left[3:0] : 4'd8;
    assign wide_addr   = {5'd0, i_cmd.off};

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.is_load) begin
            r_bitmap[wide_addr[AW-1:0]] <= i_cmd.data;
        end
        if (run_issue) begin
            r_rd <= r_bitmap[r_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && !i_cmd.is_load) begin
                    n_state = i_cmd.empty ? ST_EMPTY : ST_RUN;
                end
            end
            ST_EMPTY: begin
                if (empty_issue) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (run_issue && glyph_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_cmd;
            r_left  <= i_cmd.w;
            r_rows  <= i_cmd.h;
            r_addr  <= wide_addr[AW-1:0];
            r_seg_x <= i_cmd.x0;
            r_seg_y <= i_cmd.y0;
        end else if (run_issue) begin
            r_addr <= r_addr + 1'b1;
            if (row_end) begin
                r_left  <= r_cmd.w;
                r_rows  <= r_rows - 1'b1;
                r_seg_x <= r_cmd.x0;
                r_seg_y <= r_seg_y + 16'd1;
            end else begin
                r_left  <= r_left - 6'd8;
                r_seg_x <= r_seg_x + 16'd8;
            end
        end

        if (run_issue || empty_issue) begin
            r_o_x    <= r_seg_x;
            r_o_y    <= r_seg_y;
            r_o_cnt  <= empty_issue ? 4'd0 : step_cnt;
            r_o_adv  <= r_cmd.adv;
            r_o_sw   <= r_cmd.str_w;
            r_o_last <= empty_issue || glyph_end;
            r_o_fill <= r_cmd.fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (run_issue || empty_issue) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Pixel i of a segment is bit 7-i of the bitmap byte.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rev_line[i] = r_rd[7-i];
        end
        low_mask9 = (9'd1 << r_o_cnt) - 9'd1;
        low_mask  = low_mask9[7:0];
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.seg_x        = r_o_x;
    assign o_out.seg_y        = r_o_y;
    assign o_out.pixel_count  = r_o_cnt;
    assign o_out.fore_mask    = rev_line & low_mask;
    assign o_out.draw_mask    = r_o_fill ? low_mask : (rev_line & low_mask);
    assign o_out.char_advance = r_o_adv;
    assign o_out.string_width = r_o_sw;
    assign o_out.last         = r_o_last;

endmodule

>>> src/bitmap_font_text_renderer.sv
// Top level of the bitmap font text renderer: front end, command queue, drawing engine.
//
//   Channel   Direction  Handshake      Carries
//   i_in      in         valid/ready    load glyph, load bitmap byte, draw character
//   o_out     out        valid/ready    one row segment or empty result per beat
//   i_cfg_*   in         write enable   configuration registers 0 to 6
//
// A glyph of h rows and w pixels gives h*ceil(w/8) result beats, one per cycle from the
// bitmap store's single read port while o_out is ready. Spaces, characters outside the
// font and empty glyphs give one empty result beat; loads give none. Reset is
// synchronous and clears control state; the glyph table and bitmap store are not
// cleared. A stall on o_out holds the engine while the queue still fills from i_in.
module bitmap_font_text_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bftr_in_if.sink     i_in,
    bftr_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    bftr_pkg::t_cmd         push_cmd;
    bftr_pkg::t_cmd         head_cmd;
    bftr_pkg::t_fifo_status fifo_st;
    logic                   push;
    logic                   pop;

    bftr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fifo_st  (fifo_st),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    bftr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_st    (fifo_st)
    );

    bftr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (head_cmd),
        .i_fifo_st (fifo_st),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
